FILE: design/linear_queue_with_search_defines.svh
// Assertion macros used by the assertion checker of the linear queue.
`ifndef LINEAR_QUEUE_WITH_SEARCH_DEFINES_SVH
`define LINEAR_QUEUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define LQS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define LQS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lqs_pkg.sv
// Types and constants shared by the linear queue with search.
`timescale 1ns / 1ps

package lqs_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned CMDQ_DEPTH  = 2;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_DISPLAY = 2'd2,
    CMD_MODIFY  = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DISP,
    S_MOD
  } back_state_e;

  typedef struct packed {
    command_e                   op;
    logic signed [DATA_W-1:0]   data_value;
    logic signed [DATA_W-1:0]   match_value;
  } cmd_t;

endpackage

FILE: design/lqs_if.sv
// Valid/ready channel interfaces for the command input and the result output.
`timescale 1ns / 1ps

interface lqs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] data_value;
  logic signed [31:0] match_value;

  modport source (output valid, output command, output data_value, output match_value,
                  input ready);
  modport sink   (input valid, input command, input data_value, input match_value,
                  output ready);
endinterface

interface lqs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] value;
  logic [2:0]         slot_index;
  logic               last;

  modport source (output valid, output status, output value, output slot_index,
                  output last, input ready);
  modport sink   (input valid, input status, input value, input slot_index,
                  input last, output ready);
endinterface

FILE: design/lqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds while no read is issued.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/lqs_front.sv
// Front end: accepts input transactions, decodes the command and queues them.
`timescale 1ns / 1ps

module lqs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  lqs_in_if.sink        in_i,
  output logic          cmd_valid_o,
  output lqs_pkg::cmd_t cmd_o,
  input  logic          cmd_take_i
);

  import lqs_pkg::*;

  localparam int unsigned PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             fifo_q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;
  cmd_t             entry;

  assign in_i.ready  = (count_q != CNT_W'(CMDQ_DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign pop         = cmd_take_i && cmd_valid_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    entry.op          = command_e'(in_i.command);
    entry.data_value  = in_i.data_value;
    entry.match_value = in_i.match_value;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

FILE: design/lqs_back.sv
// Back end: executes queued commands against the entry memory and registers results.
`timescale 1ns / 1ps

module lqs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  lqs_pkg::cmd_t cmd_i,
  output logic          cmd_take_o,
  lqs_out_if.source     out_o
);

  import lqs_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

  back_state_e state_q, state_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic             empty_q, empty_d;
  logic [PTR_W-1:0] idx_q, idx_d;
  cmd_t             act_q, act_d;

  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic              load_ok;
  logic              at_tail;
  logic              hit;
  logic              emit;
  status_e           e_status;
  logic [DATA_W-1:0] e_value;
  logic [SLOT_W-1:0] e_slot;
  logic              e_last;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_value_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_last_q;

  lqs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The result register can take a new result when it is empty or being drained.
  assign load_ok = !out_valid_q || out_o.ready;
  assign at_tail = (idx_q == tail_q);
  assign hit     = (ram_rdata == act_q.match_value);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && load_ok && !empty_q) begin
          case (cmd_i.op)
            CMD_POP:     state_d = S_POP;
            CMD_DISPLAY: state_d = S_DISP;
            CMD_MODIFY:  state_d = S_MOD;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_POP: begin
        if (load_ok) begin
          state_d = S_IDLE;
        end
      end
      S_DISP: begin
        if (load_ok && at_tail) begin
          state_d = S_IDLE;
        end
      end
      S_MOD: begin
        if (load_ok && (hit || at_tail)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control and result generation.
  always_comb begin
    cmd_take_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = act_q.data_value;
    ram_re     = 1'b0;
    ram_raddr  = idx_q;
    emit       = 1'b0;
    e_status   = STATUS_OK;
    e_value    = '0;
    e_slot     = '0;
    e_last     = 1'b1;
    head_d     = head_q;
    tail_d     = tail_q;
    empty_d    = empty_q;
    idx_d      = idx_q;
    act_d      = act_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && load_ok) begin
          cmd_take_o = 1'b1;
          act_d      = cmd_i;
          case (cmd_i.op)
            CMD_PUSH: begin
              emit = 1'b1;
              if (!empty_q && tail_q == LAST_SLOT) begin
                e_status = STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = empty_q ? '0 : tail_q + PTR_W'(1);
                ram_wdata = cmd_i.data_value;
                tail_d    = ram_waddr;
                if (empty_q) begin
                  head_d = '0;
                end
                empty_d = 1'b0;
              end
            end
            default: begin
              if (empty_q) begin
                emit     = 1'b1;
                e_status = STATUS_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_q;
                idx_d     = head_q;
              end
            end
          endcase
        end
      end
      S_POP: begin
        if (load_ok) begin
          emit    = 1'b1;
          e_value = ram_rdata;
          if (head_q == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else begin
            head_d = head_q + PTR_W'(1);
          end
        end
      end
      S_DISP: begin
        if (load_ok) begin
          emit    = 1'b1;
          e_value = ram_rdata;
          e_slot  = SLOT_W'(idx_q);
          e_last  = at_tail;
          if (!at_tail) begin
            idx_d     = idx_q + PTR_W'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q + PTR_W'(1);
          end
        end
      end
      S_MOD: begin
        if (hit) begin
          if (load_ok) begin
            ram_we = 1'b1;
            emit   = 1'b1;
            e_slot = SLOT_W'(idx_q);
          end
        end else if (at_tail) begin
          if (load_ok) begin
            emit     = 1'b1;
            e_status = STATUS_NOT_FOUND;
          end
        end else begin
          idx_d     = idx_q + PTR_W'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_q + PTR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      idx_q   <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    if (emit) begin
      out_status_q <= e_status;
      out_value_q  <= e_value;
      out_slot_q   <= e_slot;
      out_last_q   <= e_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.value      = out_value_q;
  assign out_o.slot_index = out_slot_q;
  assign out_o.last       = out_last_q;

endmodule

FILE: design/linear_queue_with_search.sv
// Top level of the linear queue with push, pop, display and modify-first-match.
`timescale 1ns / 1ps

// A push, and any command rejected as full or empty, has its result registered in the
// cycle it is taken. A pop reads the head entry and returns it; a display returns the
// held entries from the head; a modify examines entries from the head until the first
// match (all of them if none matches). The entry memory has a single read port with
// registered read data and returns one entry per cycle, for a display only while
// results can be taken. Commands wait in a two-entry queue in front of the execution
// unit and each result sits in an output register, so inputs are still accepted while
// a result is stalled, until that queue fills. Freed slots are reused only after the
// queue empties; it reports full once the tail reaches the last of its eight slots.
module linear_queue_with_search (
  input  logic      clk_i,
  input  logic      rst_ni,
  lqs_in_if.sink    in_i,
  lqs_out_if.source out_o
);

  import lqs_pkg::*;

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  lqs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  lqs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .out_o       (out_o)
  );

endmodule

FILE: design/lqs_checker.sv
// Port-level assertions for the linear queue and the bind that attaches them.
`timescale 1ns / 1ps
`include "linear_queue_with_search_defines.svh"

module lqs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [1:0]         out_status_i,
  input logic signed [31:0] out_value_i,
  input logic [2:0]         out_slot_index_i,
  input logic               out_last_i
);

  import lqs_pkg::*;

  // Commands accepted whose final result has not been delivered yet.
  logic [3:0]  pending_q;
  logic        in_acc, out_done;
  logic        err_res, err_data_zero, out_stall;
  logic [37:0] res_bits;

  assign in_acc        = in_valid_i && in_ready_i;
  assign out_done      = out_valid_i && out_ready_i && out_last_i;
  assign err_res       = out_valid_i && (out_status_i != STATUS_OK);
  assign err_data_zero = (out_value_i == 32'sd0) && (out_slot_index_i == 3'd0);
  assign out_stall     = out_valid_i && !out_ready_i;
  assign res_bits      = {out_status_i, out_value_i, out_slot_index_i, out_last_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(in_acc) - 4'(out_done);
    end
  end

  `LQS_ASSERT_IMP(a_no_spurious, out_valid_i, pending_q != 4'd0, "result without a command")
  `LQS_ASSERT_IMP(a_error_is_last, err_res, out_last_i, "error result is not the final one")
  `LQS_ASSERT_IMP(a_error_no_data, err_res, err_data_zero, "error result carries data")
  `LQS_ASSERT_NXT(a_out_hold, out_stall, out_valid_i && $stable(res_bits), "held result changed")

endmodule

bind linear_queue_with_search lqs_checker u_lqs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_status_i     (out_o.status),
  .out_value_i      (out_o.value),
  .out_slot_index_i (out_o.slot_index),
  .out_last_i       (out_o.last)
);

FILE: tb/sv/linear_queue_with_search_tb.sv
// Self-checking testbench for the linear queue with search: directed table, then random traffic.
`timescale 1ns / 1ps

module linear_queue_with_search_tb;
  import lqs_pkg::*;

  localparam int unsigned QDEPTH       = QUEUE_DEPTH;
  localparam int unsigned N_RANDOM     = 395;
  localparam int unsigned CALM_ITEMS   = 60;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned N_DIRECTED   = 25;

  typedef struct {
    status_e            status;
    logic signed [31:0] value;
    logic [2:0]         slot;
    logic               last;
  } result_t;

  // One command; when typed is set, the single result written in the row is expected.
  typedef struct {
    command_e           op;
    logic signed [31:0] data_value;
    logic signed [31:0] match_value;
    bit                 typed;
    status_e            status;
    logic signed [31:0] value;
    logic [2:0]         slot;
  } step_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lqs_in_if  in_ch ();
  lqs_out_if out_ch ();

  linear_queue_with_search dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the queue contents and pointers.
  logic signed [31:0] q_data [QDEPTH];
  logic [2:0]         q_head  = '0;
  logic [2:0]         q_tail  = '0;
  bit                 q_empty = 1'b1;

  result_t     expected_results[$];
  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned op_count[4];
  int unsigned status_seen[4];

  step_t directed_steps[N_DIRECTED] = '{
    '{CMD_POP,     0, 0, 1, STATUS_EMPTY, 0, 0},
    '{CMD_DISPLAY, 0, 0, 1, STATUS_EMPTY, 0, 0},
    '{CMD_MODIFY,  0, 0, 1, STATUS_EMPTY, 0, 0},
    '{CMD_PUSH,    32'sh7FFFFFFF, 0, 1, STATUS_OK, 0, 0},
    '{CMD_PUSH,    32'sh80000000, 0, 1, STATUS_OK, 0, 0},
    '{CMD_PUSH,    0, 32'sh7FFFFFFF, 1, STATUS_OK, 0, 0},
    '{CMD_PUSH,    -32'sd1, 32'sh80000000, 1, STATUS_OK, 0, 0},
    '{CMD_DISPLAY, 0, 0, 0, STATUS_OK, 0, 0},
    '{CMD_MODIFY,  5, 0, 1, STATUS_OK, 0, 2},
    '{CMD_MODIFY,  7, 12345, 1, STATUS_NOT_FOUND, 0, 0},
    '{CMD_POP,     0, 0, 1, STATUS_OK, 32'sh7FFFFFFF, 0},
    '{CMD_PUSH,    1, 0, 1, STATUS_OK, 0, 0},
    '{CMD_PUSH,    2, 0, 1, STATUS_OK, 0, 0},
    '{CMD_PUSH,    3, 0, 1, STATUS_OK, 0, 0},
    '{CMD_PUSH,    4, 0, 1, STATUS_OK, 0, 0},
    '{CMD_PUSH,    5, 0, 1, STATUS_FULL, 0, 0},
    '{CMD_DISPLAY, 0, 0, 0, STATUS_OK, 0, 0},
    '{CMD_MODIFY,  32'sh55555555, -32'sd1, 0, STATUS_OK, 0, 0},
    '{CMD_POP,     0, 0, 0, STATUS_OK, 0, 0},
    '{CMD_POP,     0, 0, 0, STATUS_OK, 0, 0},
    '{CMD_POP,     0, 0, 0, STATUS_OK, 0, 0},
    '{CMD_POP,     0, 0, 0, STATUS_OK, 0, 0},
    '{CMD_POP,     0, 0, 0, STATUS_OK, 0, 0},
    '{CMD_POP,     0, 0, 0, STATUS_OK, 0, 0},
    '{CMD_POP,     0, 0, 0, STATUS_OK, 0, 0}
  };

  function automatic void add_result(status_e st, logic signed [31:0] val, logic [2:0] slot,
                                     logic last);
    result_t r;
    r.status = st;
    r.value  = val;
    r.slot   = slot;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  // Updates the shadow queue for one command and queues the results it causes.
  function automatic void predict_queue_op(command_e op, logic signed [31:0] dv,
                                           logic signed [31:0] mv);
    int  i;
    bit  found;
    case (op)
      CMD_PUSH: begin
        if (!q_empty && q_tail == QDEPTH - 1) begin
          add_result(STATUS_FULL, 0, 0, 1'b1);
        end else begin
          if (q_empty) begin
            q_head  = '0;
            q_tail  = '0;
            q_empty = 1'b0;
          end else begin
            q_tail = q_tail + 3'd1;
          end
          q_data[q_tail] = dv;
          add_result(STATUS_OK, 0, 0, 1'b1);
        end
      end
      CMD_POP: begin
        if (q_empty) begin
          add_result(STATUS_EMPTY, 0, 0, 1'b1);
        end else begin
          add_result(STATUS_OK, q_data[q_head], 0, 1'b1);
          if (q_head == q_tail) begin
            q_head  = '0;
            q_tail  = '0;
            q_empty = 1'b1;
          end else begin
            q_head = q_head + 3'd1;
          end
        end
      end
      CMD_DISPLAY: begin
        if (q_empty) begin
          add_result(STATUS_EMPTY, 0, 0, 1'b1);
        end else begin
          for (i = q_head; i <= q_tail; i++) begin
            add_result(STATUS_OK, q_data[i[2:0]], i[2:0], i == q_tail);
          end
        end
      end
      default: begin
        if (q_empty) begin
          add_result(STATUS_EMPTY, 0, 0, 1'b1);
        end else begin
          found = 1'b0;
          for (i = q_head; i <= q_tail && !found; i++) begin
            if (q_data[i[2:0]] == mv) begin
              q_data[i[2:0]] = dv;
              found          = 1'b1;
              add_result(STATUS_OK, 0, i[2:0], 1'b1);
            end
          end
          if (!found) begin
            add_result(STATUS_NOT_FOUND, 0, 0, 1'b1);
          end
        end
      end
    endcase
  endfunction

  // Small values make duplicates likely, so the first-match rule of modify gets exercised.
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 9) < 3) begin
      return $urandom_range(0, 3);
    end
    return $urandom;
  endfunction

  // Weights depend on the fill state so the queue keeps filling up and draining.
  function automatic step_t random_step();
    step_t       s;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (q_empty) begin
      s.op = (roll < 70) ? CMD_PUSH : (roll < 80) ? CMD_POP :
             (roll < 90) ? CMD_DISPLAY : CMD_MODIFY;
    end else if (q_tail == QDEPTH - 1) begin
      s.op = (roll < 10) ? CMD_PUSH : (roll < 60) ? CMD_POP :
             (roll < 75) ? CMD_DISPLAY : CMD_MODIFY;
    end else begin
      s.op = (roll < 40) ? CMD_PUSH : (roll < 65) ? CMD_POP :
             (roll < 80) ? CMD_DISPLAY : CMD_MODIFY;
    end
    s.data_value = pick_value();
    if (!q_empty && $urandom_range(0, 9) < 7) begin
      s.match_value = q_data[3'($urandom_range(q_head, q_tail))];
    end else begin
      s.match_value = pick_value();
    end
    s.typed  = 1'b0;
    s.status = STATUS_OK;
    s.value  = 0;
    s.slot   = 0;
    return s;
  endfunction

  task automatic send_command(input step_t s);
    result_t typed_res;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.command     = s.op;
    in_ch.data_value  = s.data_value;
    in_ch.match_value = s.match_value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_queue_op(s.op, s.data_value, s.match_value);
    if (s.typed) begin
      // Rows with a written-out answer cause exactly one result.
      typed_res.status = s.status;
      typed_res.value  = s.value;
      typed_res.slot   = s.slot;
      typed_res.last   = 1'b1;
      void'(expected_results.pop_back());
      expected_results.push_back(typed_res);
    end
    op_count[s.op]++;
    @(negedge clk);
  endtask

  // Result side: random stall bursts, no new ones once the run has calmed down.
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      out_ch.ready = (stall_left == 0);
      if (stall_left != 0) begin
        stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d value %0d slot %0d",
                 $time, out_ch.status, out_ch.value, out_ch.slot_index);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        status_seen[want.status]++;
        if (out_ch.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_ch.status);
          mismatches++;
        end
        if (out_ch.value !== want.value) begin
          $display("%0t: value mismatch, expected %0d, actual %0d",
                   $time, want.value, out_ch.value);
          mismatches++;
        end
        if (out_ch.slot_index !== want.slot) begin
          $display("%0t: slot_index mismatch, expected %0d, actual %0d",
                   $time, want.slot, out_ch.slot_index);
          mismatches++;
        end
        if (out_ch.last !== want.last) begin
          $display("%0t: last mismatch, expected %0d, actual %0d",
                   $time, want.last, out_ch.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction happens on either channel for too long.
  always @(posedge clk) begin
    int unsigned quiet_cycles;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
        $display("Mismatches found");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  initial begin
    int unsigned k;
    bit          hold_off;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_PUSH;
    in_ch.data_value  = '0;
    in_ch.match_value = '0;
    foreach (q_data[i]) q_data[i] = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (k = 0; k < N_DIRECTED; k++) begin
      send_command(directed_steps[k]);
    end

    for (k = 0; k < N_RANDOM; k++) begin
      if (k >= N_RANDOM - CALM_ITEMS) begin
        calm = 1'b1;
      end
      // Now and then hold off until every outstanding result has drained.
      hold_off = (k == N_RANDOM / 2) || (!calm && $urandom_range(0, 99) == 0);
      if (hold_off && expected_results.size() != 0) begin
        in_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
      end
      send_command(random_step());
    end
    in_ch.valid = 1'b0;

    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Commands sent: %0d push, %0d pop, %0d display, %0d modify",
             op_count[CMD_PUSH], op_count[CMD_POP], op_count[CMD_DISPLAY],
             op_count[CMD_MODIFY]);
    $display("Results checked: %0d ok, %0d full, %0d empty, %0d not found",
             status_seen[STATUS_OK], status_seen[STATUS_FULL], status_seen[STATUS_EMPTY],
             status_seen[STATUS_NOT_FOUND]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
